// ===== hw/rtl/smx_pkg.sv =====
// Shared types and constants for the stack machine executor.
package smx_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 13;

  localparam logic [7:0] OP_PUSH = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DUP  = 8'd5;
  localparam logic [7:0] OP_SWAP = 8'd6;
  localparam logic [7:0] OP_JMPZ = 8'd7;
  localparam logic [7:0] OP_JMP  = 8'd8;
  localparam logic [7:0] OP_HALT = 8'd9;

  // What a stack cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_UP   = 2'd1,
    CELL_DOWN = 2'd2,
    CELL_LOAD = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t          mode;
    logic [WORD_W-1:0]   data;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/smx_in_if.sv =====
// Instruction channel: one fetched instruction per word.
interface smx_in_if;
  import smx_pkg::*;

  logic              valid;
  logic              ready;
  logic [7:0]        cmd;
  logic signed [31:0] operand;
  logic              start_req;

  modport source (output valid, output cmd, output operand, output start_req, input ready);
  modport sink   (input valid, input cmd, input operand, input start_req, output ready);
endinterface

// ===== hw/rtl/smx_out_if.sv =====
// Result channel: one status word per executed instruction.
interface smx_out_if;
  import smx_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   next_pc;
  logic signed [31:0] result_value;
  logic               done_res;
  logic               fault;

  modport source (output valid, output next_pc, output result_value, output done_res,
                  output fault, input ready);
  modport sink   (input valid, input next_pc, input result_value, input done_res,
                  input fault, output ready);
endinterface

// ===== hw/rtl/smx_alu.sv =====
// Wrapping add, subtract and multiply on the top two stack entries.
module smx_alu
  import smx_pkg::*;
(
  input  logic [7:0]        op,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] y
);

  always_comb begin
    case (op)
      OP_ADD:  y = a + b;
      OP_SUB:  y = a - b;
      OP_MUL:  y = a * b;
      default: y = '0;
    endcase
  end

endmodule

// ===== hw/rtl/smx_cell.sv =====
// One stack entry: holds, shifts toward the top, shifts away from it, or loads.
module smx_cell
  import smx_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] above,
  input  logic [WORD_W-1:0] below,
  output logic [WORD_W-1:0] value
);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CELL_UP:   value <= below;
      CELL_DOWN: value <= above;
      CELL_LOAD: value <= ctl.data;
      default:   value <= value;
    endcase
  end

endmodule

// ===== hw/rtl/stack_machine_executor.sv =====
// Stack machine executor: one instruction per cycle over a chain of stack cells, unless results stall.
// A result word is registered and appears in the cycle after its instruction is accepted.
// Throughput: one instruction per cycle while res.ready holds; the stack top sits in cell 0, so every
//   opcode is a single shift, load or hold of the cell chain plus one multiplier.
// Reset clears depth, pc, flags, length and the output valid; cell contents are
//   left as they are and are only read below the current depth.
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int PROG_DEPTH  = 4096
) (
  input  logic             clk,
  input  logic             rst,
  smx_in_if.sink           instr,
  smx_out_if.source        res,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int PW0  = $clog2(PROG_DEPTH + 1);
  localparam int PC_W = (PW0 > LEN_W) ? PW0 : LEN_W;

  logic [LEN_W-1:0]  program_length;
  logic [DW-1:0]     depth;
  logic [PC_W-1:0]   pc;
  logic              fault_flag;
  logic              stopped;

  logic [WORD_W-1:0] cell_q [STACK_DEPTH];
  cell_ctl_t         ctl0, ctl1, ctl_rest;
  cell_ctl_t         ctl0_g, ctl1_g, ctl_rest_g;

  logic              take;
  logic              start;
  logic [DW-1:0]     d_e, depth_next;
  logic [PC_W-1:0]   pc_e, pc_next, limit, len_ext, pc_inc;
  logic              flt_e, stp_e, fault_next, stopped_next, run, halt;
  logic              has1, has2, full, tgt_ok, cond_zero;
  logic [WORD_W-1:0] c0, c1, alu_y, top_next, value_next;

  assign take  = instr.valid && instr.ready;
  assign instr.ready = !res.valid || res.ready;
  assign start = instr.start_req;

  assign d_e   = start ? '0 : depth;
  assign pc_e  = start ? '0 : pc;
  assign flt_e = start ? 1'b0 : fault_flag;
  assign stp_e = start ? 1'b0 : stopped;

  assign len_ext = PC_W'(program_length);
  assign limit   = (len_ext > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : len_ext;
  assign run     = !stp_e && !flt_e && (pc_e < limit);

  assign c0     = cell_q[0];
  assign c1     = cell_q[1];
  assign has1   = d_e != '0;
  assign has2   = d_e >= DW'(2);
  assign full   = d_e == DW'(STACK_DEPTH);
  // Negative targets compare as large unsigned values and fail.
  assign tgt_ok = $unsigned(instr.operand) < 32'(PROG_DEPTH);
  assign pc_inc = pc_e + PC_W'(1);

  smx_alu u_alu (
    .op (instr.cmd),
    .a  (c1),
    .b  (c0),
    .y  (alu_y)
  );

  always_comb begin
    ctl0       = '{mode: CELL_HOLD, data: '0};
    ctl1       = '{mode: CELL_HOLD, data: '0};
    ctl_rest   = '{mode: CELL_HOLD, data: '0};
    depth_next = d_e;
    pc_next    = pc_e;
    fault_next = flt_e;
    halt       = 1'b0;
    top_next   = c0;
    cond_zero  = 1'b0;
    if (run) begin
      case (instr.cmd)
        OP_PUSH: begin
          if (full) begin
            fault_next = 1'b1;
          end else begin
            ctl0       = '{mode: CELL_LOAD, data: instr.operand};
            ctl1.mode  = CELL_DOWN;
            ctl_rest.mode = CELL_DOWN;
            depth_next = d_e + DW'(1);
            top_next   = instr.operand;
          end
          pc_next = pc_inc;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          if (!has2) begin
            fault_next = 1'b1;
          end else begin
            ctl0       = '{mode: CELL_LOAD, data: alu_y};
            ctl1.mode  = CELL_UP;
            ctl_rest.mode = CELL_UP;
            depth_next = d_e - DW'(1);
            top_next   = alu_y;
          end
          pc_next = pc_inc;
        end
        OP_DUP: begin
          if (!has1 || full) begin
            fault_next = 1'b1;
          end else begin
            ctl1.mode  = CELL_DOWN;
            ctl_rest.mode = CELL_DOWN;
            depth_next = d_e + DW'(1);
          end
          pc_next = pc_inc;
        end
        OP_SWAP: begin
          if (!has2) begin
            fault_next = 1'b1;
          end else begin
            ctl0     = '{mode: CELL_LOAD, data: c1};
            ctl1     = '{mode: CELL_LOAD, data: c0};
            top_next = c1;
          end
          pc_next = pc_inc;
        end
        OP_JMPZ: begin
          // An empty stack pops as zero, so the jump is still taken, but a fault is raised.
          if (!has1) begin
            fault_next = 1'b1;
            cond_zero  = 1'b1;
          end else begin
            ctl0.mode  = CELL_UP;
            ctl1.mode  = CELL_UP;
            ctl_rest.mode = CELL_UP;
            depth_next = d_e - DW'(1);
            top_next   = c1;
            cond_zero  = c0 == '0;
          end
          if (cond_zero) begin
            if (tgt_ok) begin
              pc_next = instr.operand[PC_W-1:0];
            end else begin
              fault_next = 1'b1;
            end
          end else begin
            pc_next = pc_inc;
          end
        end
        OP_JMP: begin
          if (tgt_ok) begin
            pc_next = instr.operand[PC_W-1:0];
          end else begin
            fault_next = 1'b1;
          end
        end
        OP_HALT: begin
          halt = 1'b1;
        end
        default: begin
          fault_next = 1'b1;
        end
      endcase
    end
    stopped_next = stp_e || halt || fault_next || (pc_next >= limit);
    if (fault_next) begin
      value_next = '1;
    end else if (depth_next == '0) begin
      value_next = '0;
    end else begin
      value_next = top_next;
    end
  end

  // Hold the chain unless a word is taken.
  always_comb begin
    ctl0_g     = ctl0;
    ctl1_g     = ctl1;
    ctl_rest_g = ctl_rest;
    if (!take) begin
      ctl0_g.mode     = CELL_HOLD;
      ctl1_g.mode     = CELL_HOLD;
      ctl_rest_g.mode = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] above, below;
    cell_ctl_t         ctl;
    if (i == 0) begin : g_top
      assign above = '0;
      assign ctl   = ctl0_g;
    end else begin : g_mid
      assign above = cell_q[i-1];
      assign ctl   = (i == 1) ? ctl1_g : ctl_rest_g;
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    smx_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .value (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      depth          <= '0;
      pc             <= '0;
      fault_flag     <= 1'b0;
      stopped        <= 1'b0;
      res.valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        program_length <= cfg_wr_data;
      end
      if (take) begin
        depth      <= depth_next;
        pc         <= pc_next;
        fault_flag <= fault_next;
        stopped    <= stopped_next;
        res.valid  <= 1'b1;
      end else if (res.ready) begin
        res.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.next_pc      <= pc_next[LEN_W-1:0];
      res.result_value <= value_next;
      res.done_res     <= stopped_next || fault_next;
      res.fault        <= fault_next;
    end
  end

endmodule
